// File: rtl/joystick_byte_decode_drive_mixer_macros.svh
// Assertion macros for the joystick byte decode drive mixer.
// Used by the top level only; each macro expects clk and rst_n in scope.
`ifndef JOYSTICK_BYTE_DECODE_DRIVE_MIXER_MACROS_SVH
`define JOYSTICK_BYTE_DECODE_DRIVE_MIXER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jbd assertion failed");

// Next-cycle implication, checked out of reset.
`define JBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jbd assertion failed");

`endif

// File: rtl/jbd_pkg.sv
// Shared types, codes and helpers for the joystick byte decode drive mixer.
// No dependencies.
package jbd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned BTN_W    = 2;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned EFFORT_W = 10;  // y +/- x spans -256..255
  localparam int unsigned MAG_W    = 9;   // magnitudes up to 256

  localparam logic [CFG_W-1:0] DUTY_GAIN_RST  = 8'd120;
  localparam logic [CFG_W-1:0] DEAD_BAND_RST  = 8'd5;
  localparam logic [CFG_W-1:0] ACT_THRESH_RST = 8'd20;

  typedef enum logic [2:0] {
    TAG_X_HI   = 3'd0,
    TAG_X_LO   = 3'd1,
    TAG_Y_HI   = 3'd2,
    TAG_Y_LO   = 3'd3,
    TAG_SW_A   = 3'd4,
    TAG_SW_B   = 3'd5,
    TAG_BUTTON = 3'd6,
    TAG_UNUSED = 3'd7
  } tag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_GAIN  = 2'd0,
    REG_DEAD_BAND  = 2'd1,
    REG_ACT_THRESH = 2'd2
  } cfg_reg_t;

  // Decoded stick state handed from the decoder to the mixer.
  typedef struct packed {
    logic signed [BYTE_W-1:0] x;
    logic signed [BYTE_W-1:0] y;
    logic                     stop_btn;
  } stick_t;

  function automatic logic [MAG_W-1:0] abs_axis(input logic signed [BYTE_W-1:0] v);
    logic signed [MAG_W-1:0] w;
    w = MAG_W'(v);
    abs_axis = w[MAG_W-1] ? MAG_W'(-w) : MAG_W'(w);
  endfunction

endpackage

// File: rtl/joystick_byte_decode_drive_mixer.sv
// Top level of the joystick byte decode drive mixer: handshake, config
// registers, differential mix and result register. Depends on jbd_pkg,
// jbd_decode, jbd_side and the assertion macro header.
//
// Usage:
//   in_*  : one link byte per transfer (valid/ready). Bits 7..5 tag the field,
//           bits 3..0 carry the nibble; bit 4 is ignored.
//   out_* : one result per input byte, the four PWM compare counts.
//   cfg_* : register writes (gain, deadband, activation threshold); always
//           ready. Write only while the block is idle.
// Timing: an accepted byte updates the stored stick state as it is taken; its
//   result is then loaded into the output register when the output is free.
//   Throughput is one byte per cycle unless the output stalls: the stored stick
//   state is the input stage and the output register the result stage, with one
//   short path of two narrow adds, compares and two 8x9 multipliers between them.
// Stall: while a result waits on out_ready, one more byte is still taken into
//   the input stage; in_ready drops only when both stages are full.
// Reset: stick nibbles and buttons clear to zero, config returns to its
//   default values, and both stages empty.
`include "joystick_byte_decode_drive_mixer_macros.svh"

module joystick_byte_decode_drive_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [jbd_pkg::BYTE_W-1:0]          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [jbd_pkg::DUTY_W-1:0]          out_left_forward_duty,
  output logic [jbd_pkg::DUTY_W-1:0]          out_left_reverse_duty,
  output logic [jbd_pkg::DUTY_W-1:0]          out_right_forward_duty,
  output logic [jbd_pkg::DUTY_W-1:0]          out_right_reverse_duty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jbd_pkg::CFG_W-1:0]           cfg_data
);

  // Config registers
  logic [jbd_pkg::CFG_W-1:0] gain_r, gain_nxt;
  logic [jbd_pkg::CFG_W-1:0] dead_r, dead_nxt;
  logic [jbd_pkg::CFG_W-1:0] thresh_r, thresh_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    gain_nxt   = gain_r;
    dead_nxt   = dead_r;
    thresh_nxt = thresh_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        jbd_pkg::REG_DUTY_GAIN:  gain_nxt   = cfg_data;
        jbd_pkg::REG_DEAD_BAND:  dead_nxt   = cfg_data;
        jbd_pkg::REG_ACT_THRESH: thresh_nxt = cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= jbd_pkg::DUTY_GAIN_RST;
      dead_r   <= jbd_pkg::DEAD_BAND_RST;
      thresh_r <= jbd_pkg::ACT_THRESH_RST;
    end else begin
      gain_r   <= gain_nxt;
      dead_r   <= dead_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  // Pipeline control: input stage (stick state) then result register.
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic in_xfer;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stick state: advances only on an input transfer, so it always matches
  // the byte held in the input stage.
  jbd_pkg::stick_t stick;

  jbd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_xfer),
    .rx_byte (in_rx_byte),
    .stick   (stick)
  );

  // Mix: enable on either axis reaching the threshold, unless stop button set.
  logic [jbd_pkg::MAG_W-1:0]           mag_x;
  logic [jbd_pkg::MAG_W-1:0]           mag_y;
  logic [jbd_pkg::MAG_W-1:0]           thresh_ext;
  logic                                active;
  logic signed [jbd_pkg::EFFORT_W-1:0] x_ext;
  logic signed [jbd_pkg::EFFORT_W-1:0] y_ext;
  logic signed [jbd_pkg::EFFORT_W-1:0] left_effort;
  logic signed [jbd_pkg::EFFORT_W-1:0] right_effort;

  assign mag_x       = jbd_pkg::abs_axis(stick.x);
  assign mag_y       = jbd_pkg::abs_axis(stick.y);
  assign thresh_ext  = jbd_pkg::MAG_W'(thresh_r);
  assign active      = ((mag_x >= thresh_ext) || (mag_y >= thresh_ext)) && !stick.stop_btn;
  assign x_ext       = jbd_pkg::EFFORT_W'(stick.x);
  assign y_ext       = jbd_pkg::EFFORT_W'(stick.y);
  assign left_effort  = y_ext + x_ext;
  assign right_effort = y_ext - x_ext;

  logic [jbd_pkg::DUTY_W-1:0] lf_duty, lr_duty, rf_duty, rr_duty;

  jbd_side u_left (
    .enable    (active),
    .effort    (left_effort),
    .gain      (gain_r),
    .dead_band (dead_r),
    .fwd_duty  (lf_duty),
    .rev_duty  (lr_duty)
  );

  jbd_side u_right (
    .enable    (active),
    .effort    (right_effort),
    .gain      (gain_r),
    .dead_band (dead_r),
    .fwd_duty  (rf_duty),
    .rev_duty  (rr_duty)
  );

  // Result register: load when the input stage hands over, hold on stall.
  logic [jbd_pkg::DUTY_W-1:0] lf_r, lr_r, rf_r, rr_r;
  logic [jbd_pkg::DUTY_W-1:0] lf_nxt, lr_nxt, rf_nxt, rr_nxt;
  logic                       load_out;

  assign load_out = advance && s1_valid_r;
  assign lf_nxt   = load_out ? lf_duty : lf_r;
  assign lr_nxt   = load_out ? lr_duty : lr_r;
  assign rf_nxt   = load_out ? rf_duty : rf_r;
  assign rr_nxt   = load_out ? rr_duty : rr_r;

  always_ff @(posedge clk) begin
    lf_r <= lf_nxt;
    lr_r <= lr_nxt;
    rf_r <= rf_nxt;
    rr_r <= rr_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_left_forward_duty  = lf_r;
  assign out_left_reverse_duty  = lr_r;
  assign out_right_forward_duty = rf_r;
  assign out_right_reverse_duty = rr_r;

  // Checks
  `JBD_ASSERT_IMP(a_left_one_dir, out_valid && (lf_r != '0), lr_r == '0)
  `JBD_ASSERT_IMP(a_right_one_dir, out_valid && (rf_r != '0), rr_r == '0)
  `JBD_ASSERT_NXT(a_handover, s1_valid_r && advance, out_valid_r)
  `JBD_ASSERT_NXT(a_stop_zero, load_out && stick.stop_btn, {lf_r, lr_r, rf_r, rr_r} == '0)

endmodule

// File: rtl/jbd_decode.sv
// Link byte decoder: tag decode and stored stick nibbles / button bits.
// Depends on jbd_pkg.
module jbd_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [jbd_pkg::BYTE_W-1:0]    rx_byte,
  output jbd_pkg::stick_t               stick
);

  logic [jbd_pkg::NIB_W-1:0] x_hi_r, x_hi_nxt;
  logic [jbd_pkg::NIB_W-1:0] x_lo_r, x_lo_nxt;
  logic [jbd_pkg::NIB_W-1:0] y_hi_r, y_hi_nxt;
  logic [jbd_pkg::NIB_W-1:0] y_lo_r, y_lo_nxt;
  logic [jbd_pkg::BTN_W-1:0] btn_r, btn_nxt;
  logic [jbd_pkg::NIB_W-1:0] nib;
  jbd_pkg::tag_t             tag;

  assign nib = rx_byte[jbd_pkg::NIB_W-1:0];
  assign tag = jbd_pkg::tag_t'(rx_byte[7:5]);

  always_comb begin
    x_hi_nxt = x_hi_r;
    x_lo_nxt = x_lo_r;
    y_hi_nxt = y_hi_r;
    y_lo_nxt = y_lo_r;
    btn_nxt  = btn_r;
    if (load) begin
      unique case (tag)
        jbd_pkg::TAG_X_HI:   x_hi_nxt = nib;
        jbd_pkg::TAG_X_LO:   x_lo_nxt = nib;
        jbd_pkg::TAG_Y_HI:   y_hi_nxt = nib;
        jbd_pkg::TAG_Y_LO:   y_lo_nxt = nib;
        jbd_pkg::TAG_BUTTON: btn_nxt  = rx_byte[jbd_pkg::BTN_W-1:0];
        jbd_pkg::TAG_SW_A,
        jbd_pkg::TAG_SW_B,
        jbd_pkg::TAG_UNUSED: ;  // drop: no stored field
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_hi_r <= '0;
      x_lo_r <= '0;
      y_hi_r <= '0;
      y_lo_r <= '0;
      btn_r  <= '0;
    end else begin
      x_hi_r <= x_hi_nxt;
      x_lo_r <= x_lo_nxt;
      y_hi_r <= y_hi_nxt;
      y_lo_r <= y_lo_nxt;
      btn_r  <= btn_nxt;
    end
  end

  assign stick.x        = $signed({x_hi_r, x_lo_r});
  assign stick.y        = $signed({y_hi_r, y_lo_r});
  assign stick.stop_btn = btn_r[0];

endmodule

// File: rtl/jbd_side.sv
// One drive side: deadband test and gain multiply into forward/reverse counts.
// Depends on jbd_pkg.
module jbd_side (
  input  logic                                 enable,
  input  logic signed [jbd_pkg::EFFORT_W-1:0]  effort,
  input  logic [jbd_pkg::CFG_W-1:0]            gain,
  input  logic [jbd_pkg::CFG_W-1:0]            dead_band,
  output logic [jbd_pkg::DUTY_W-1:0]           fwd_duty,
  output logic [jbd_pkg::DUTY_W-1:0]           rev_duty
);

  logic signed [jbd_pkg::EFFORT_W-1:0] db_pos;
  logic signed [jbd_pkg::EFFORT_W-1:0] db_neg;
  logic signed [jbd_pkg::EFFORT_W-1:0] neg_effort;
  logic [jbd_pkg::MAG_W-1:0]           mag;
  logic [jbd_pkg::MAG_W+jbd_pkg::CFG_W-1:0] prod;
  logic                                go_fwd;
  logic                                go_rev;

  assign db_pos     = $signed(jbd_pkg::EFFORT_W'(dead_band));
  assign db_neg     = -db_pos;
  assign neg_effort = -effort;
  assign mag        = effort[jbd_pkg::EFFORT_W-1] ? neg_effort[jbd_pkg::MAG_W-1:0]
                                                  : effort[jbd_pkg::MAG_W-1:0];
  assign prod       = gain * mag;
  assign go_fwd     = enable && (effort > db_pos);
  assign go_rev     = enable && (effort < db_neg);

  assign fwd_duty = go_fwd ? prod[jbd_pkg::DUTY_W-1:0] : '0;
  assign rev_duty = go_rev ? prod[jbd_pkg::DUTY_W-1:0] : '0;

endmodule

// File: tb/joystick_byte_decode_drive_mixer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for joystick_byte_decode_drive_mixer: streams tagged
// link bytes and register writes, predicts the four duty counts of each byte.
// Depends on jbd_pkg and the joystick_byte_decode_drive_mixer top level.
module joystick_byte_decode_drive_mixer_tb;
  import jbd_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  // Nibbles that put an axis at or next to its extremes.
  localparam logic [NIB_W-1:0] CORNER_NIBS [4] = '{4'h0, 4'h7, 4'h8, 4'hF};

  typedef struct packed {
    logic [DUTY_W-1:0] lf;
    logic [DUTY_W-1:0] lr;
    logic [DUTY_W-1:0] rf;
    logic [DUTY_W-1:0] rr;
  } duties_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DUTY_W-1:0]    out_left_forward_duty;
  logic [DUTY_W-1:0]    out_left_reverse_duty;
  logic [DUTY_W-1:0]    out_right_forward_duty;
  logic [DUTY_W-1:0]    out_right_reverse_duty;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DUTY_GAIN;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Bytes waiting for the driver, and duty sets waiting for the block.
  logic [BYTE_W-1:0] byte_q [$];
  duties_t           duty_q [$];

  // Predicted stick state and register copies.
  logic [NIB_W-1:0] x_hi = '0, x_lo = '0, y_hi = '0, y_lo = '0;
  logic [BTN_W-1:0] btn = '0;
  logic [CFG_W-1:0] gain = DUTY_GAIN_RST;
  logic [CFG_W-1:0] band = DEAD_BAND_RST;
  logic [CFG_W-1:0] thresh = ACT_THRESH_RST;

  logic in_taken = 1'b0;
  int   in_gap = 0;
  int   out_hold = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  int   mismatches = 0;
  int   cycle_count = 0;

  joystick_byte_decode_drive_mixer i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_rx_byte             (in_rx_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_left_forward_duty  (out_left_forward_duty),
    .out_left_reverse_duty  (out_left_reverse_duty),
    .out_right_forward_duty (out_right_forward_duty),
    .out_right_reverse_duty (out_right_reverse_duty),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Pick an idle length: mostly none or short, now and then long. A calm
  // stretch (toggled at random) forces back-to-back traffic.
  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 99) < 3) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [BYTE_W-1:0] link_byte(input tag_t tag, input logic [NIB_W-1:0] nib,
                                                  input logic spare);
    return {tag, spare, nib};
  endfunction

  // Duty pair {forward, reverse} for one side's effort.
  function automatic logic [2*DUTY_W-1:0] side_duty(input int effort);
    int mag_e;
    mag_e = (effort < 0) ? -effort : effort;
    if (effort > int'(band))
      return {DUTY_W'(int'(gain) * effort), DUTY_W'(0)};
    else if (effort < -int'(band))
      return {DUTY_W'(0), DUTY_W'(int'(gain) * mag_e)};
    return '0;
  endfunction

  // Input driver: hold the byte until its transfer, then idle or advance.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold payload and valid
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (byte_q.size() > 0) begin
      in_valid   <= 1'b1;
      in_rx_byte <= byte_q.pop_front();
      in_gap = pick_gap(in_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side backpressure: stall for random stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      out_hold = pick_gap(out_calm);
    end
  end

  // Monitor: check each result transfer against the oldest prediction, then
  // fold each accepted byte into the stick state and predict its duties.
  always @(posedge clk) begin
    duties_t got;
    duties_t want;
    logic [BYTE_W-1:0] b;
    int xv, yv, thr;
    if (!rst_n) begin
      in_taken <= 1'b0;
      x_hi = '0;
      x_lo = '0;
      y_hi = '0;
      y_lo = '0;
      btn  = '0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = '{out_left_forward_duty, out_left_reverse_duty,
                out_right_forward_duty, out_right_reverse_duty};
        if (duty_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: lf=%0d lr=%0d rf=%0d rr=%0d",
                     got.lf, got.lr, got.rf, got.rr);
          mismatches++;
        end else begin
          want = duty_q.pop_front();
          if (got !== want) begin
            if (mismatches < MAX_REPORTS)
              $display({"duty mismatch: expected lf=%0d lr=%0d rf=%0d rr=%0d,",
                        " got lf=%0d lr=%0d rf=%0d rr=%0d"},
                       want.lf, want.lr, want.rf, want.rr,
                       got.lf, got.lr, got.rf, got.rr);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        b = in_rx_byte;
        // Switch and unused tags leave the state alone but still give a result.
        case (tag_t'(b[7:5]))
          TAG_X_HI:   x_hi = b[3:0];
          TAG_X_LO:   x_lo = b[3:0];
          TAG_Y_HI:   y_hi = b[3:0];
          TAG_Y_LO:   y_lo = b[3:0];
          TAG_BUTTON: btn  = b[1:0];
          default: ;
        endcase
        xv  = int'($signed({x_hi, x_lo}));
        yv  = int'($signed({y_hi, y_lo}));
        thr = int'(thresh);
        // Motors run when either axis reaches the threshold and stop is clear.
        if ((((xv < 0) ? -xv : xv) >= thr || ((yv < 0) ? -yv : yv) >= thr) && !btn[0]) begin
          {want.lf, want.lr} = side_duty(yv + xv);
          {want.rf, want.rr} = side_duty(yv - xv);
        end else begin
          want = '0;
        end
        duty_q.push_back(want);
      end
    end
  end

  // Watchdog: end the run with a mismatch once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Wait until every byte has gone in and every result has come out.
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || duty_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DUTY_GAIN:  gain   = val;
      REG_DEAD_BAND:  band   = val;
      REG_ACT_THRESH: thresh = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] db,
                            input logic [CFG_W-1:0] thr);
    write_reg(REG_DUTY_GAIN, g);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_ACT_THRESH, thr);
  endtask

  // Mostly axis nibbles (often at corners), some button bytes with stop
  // mostly clear, and the rest fully random bytes.
  task automatic queue_random_bytes(input int count);
    logic [BYTE_W-1:0] b;
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      b = BYTE_W'($urandom);
      if (r < 75) begin
        b[7:5] = 3'($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0) b[3:0] = CORNER_NIBS[$urandom_range(0, 3)];
      end else if (r < 88) begin
        b[7:5] = TAG_BUTTON;
        b[0]   = ($urandom_range(0, 9) < 3);
      end
      byte_q.push_back(b);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed bytes at the reset register values.
    byte_q.push_back(link_byte(TAG_X_HI, 4'h7, 1'b0));    // X = 127
    byte_q.push_back(link_byte(TAG_X_LO, 4'hF, 1'b1));
    byte_q.push_back(link_byte(TAG_Y_HI, 4'h8, 1'b0));    // Y = -128
    byte_q.push_back(link_byte(TAG_Y_LO, 4'h0, 1'b1));
    byte_q.push_back(link_byte(TAG_X_HI, 4'h8, 1'b0));    // X = -128
    byte_q.push_back(link_byte(TAG_X_LO, 4'h0, 1'b0));
    byte_q.push_back(link_byte(TAG_BUTTON, 4'h1, 1'b0));  // stop pressed
    byte_q.push_back(link_byte(TAG_SW_A, 4'hA, 1'b0));    // switch nibbles
    byte_q.push_back(link_byte(TAG_SW_B, 4'hF, 1'b1));
    byte_q.push_back(link_byte(TAG_UNUSED, 4'hF, 1'b1));  // unused tag
    byte_q.push_back(link_byte(TAG_UNUSED, 4'h0, 1'b0));
    byte_q.push_back(link_byte(TAG_BUTTON, 4'h2, 1'b0));  // stop clear, bit 1 set
    byte_q.push_back(link_byte(TAG_BUTTON, 4'h3, 1'b1));
    byte_q.push_back(link_byte(TAG_BUTTON, 4'h0, 1'b1));
    byte_q.push_back(link_byte(TAG_X_HI, 4'h0, 1'b0));    // X = 3, below threshold
    byte_q.push_back(link_byte(TAG_X_LO, 4'h3, 1'b0));
    byte_q.push_back(link_byte(TAG_Y_HI, 4'h0, 1'b0));    // Y = 1
    byte_q.push_back(link_byte(TAG_Y_LO, 4'h1, 1'b0));
    byte_q.push_back(link_byte(TAG_X_HI, 4'h1, 1'b0));    // X = 20, at threshold
    byte_q.push_back(link_byte(TAG_X_LO, 4'h4, 1'b0));
    byte_q.push_back(link_byte(TAG_Y_HI, 4'hF, 1'b0));    // Y = -1
    byte_q.push_back(link_byte(TAG_Y_LO, 4'hF, 1'b1));
    byte_q.push_back(link_byte(TAG_X_HI, 4'h0, 1'b1));    // X = 4, Y = 31
    byte_q.push_back(link_byte(TAG_Y_HI, 4'h1, 1'b0));
    wait_idle();

    // Full gain, no deadband, zero threshold: drive both axes to extremes.
    set_config(8'd255, 8'd0, 8'd0);
    byte_q.push_back(link_byte(TAG_X_HI, 4'h8, 1'b0));
    byte_q.push_back(link_byte(TAG_X_LO, 4'h0, 1'b0));
    byte_q.push_back(link_byte(TAG_Y_HI, 4'h8, 1'b0));
    byte_q.push_back(link_byte(TAG_Y_LO, 4'h0, 1'b0));    // left effort -256
    byte_q.push_back(link_byte(TAG_Y_HI, 4'h7, 1'b0));
    byte_q.push_back(link_byte(TAG_Y_LO, 4'hF, 1'b0));    // right effort 255
    queue_random_bytes(160);
    wait_idle();

    set_config(8'd0, 8'd255, 8'd128);
    queue_random_bytes(100);
    wait_idle();

    set_config(8'd1, 8'd1, 8'd1);
    queue_random_bytes(160);
    wait_idle();

    // Threshold out of the sticks' reach keeps the motors off.
    set_config(8'd255, 8'd255, 8'd200);
    queue_random_bytes(40);
    wait_idle();

    set_config(8'd200, 8'd3, 8'd128);
    queue_random_bytes(100);
    wait_idle();

    repeat (5) begin
      set_config(CFG_W'($urandom_range(0, 255)),
                 ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 15))
                                             : CFG_W'($urandom_range(0, 255)),
                 CFG_W'($urandom_range(0, 128)));
      queue_random_bytes(148);
      wait_idle();
    end

    if (mismatches == 0 && duty_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/jbd_pkg.sv
rtl/jbd_decode.sv
rtl/jbd_side.sv
rtl/joystick_byte_decode_drive_mixer.sv
tb/joystick_byte_decode_drive_mixer_tb.sv
